FILE: hdl/nhfl_pkg.sv
// Shared types and constants for the next-hop forwarding lookup block.
`default_nettype none

package nhfl_pkg;

	localparam int KEY_W      = 32;
	localparam int TOK_DATA_W = 64;
	localparam int IDX_W      = 8;
	localparam int MAC_W      = 48;
	localparam int IFN_W      = 16;

	typedef enum logic [1:0] {
		OP_LOOKUP    = 2'd0,
		OP_WR_ROUTE  = 2'd1,
		OP_WR_ARP    = 2'd2,
		OP_WR_DEVICE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_FORWARDED  = 3'd0,
		ST_NO_ROUTE   = 3'd1,
		ST_NO_ARP     = 3'd2,
		ST_NO_DEVICE  = 3'd3,
		ST_WRITE_DONE = 3'd4
	} status_t;

	// search token passed from cell to cell
	typedef struct packed {
		logic                  vld;
		logic                  hit;
		logic [KEY_W-1:0]      key;
		logic [TOK_DATA_W-1:0] data;
	} tok_t;

	// entry write broadcast to every cell of a table
	typedef struct packed {
		logic                  en;
		logic [IDX_W-1:0]      idx;
		logic [KEY_W-1:0]      key;
		logic [TOK_DATA_W-1:0] data;
	} wr_t;

	typedef struct packed {
		status_t           status;
		logic [MAC_W-1:0]  mac;
		logic [IFN_W-1:0]  ifidx;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/next_hop_forwarding_lookup_unit.sv
// Top level of the next-hop forwarding lookup block.
// Usage:
//   Slave stream carries one command per transaction: tuser holds the opcode
//   (lookup or write of a route, ARP or device entry), tdata the operands.
//   Master stream returns exactly one result per command: tuser holds the
//   status, tdata the next-hop MAC and output interface number.
//   One command is handled at a time; tready is high only while idle.
//   Write: the entry is written at acceptance and a write-done result follows;
//   the next command can be taken once that result is in the output register.
//   Lookup: the key walks the route cells one per cycle, then the gateway and
//   interface keys walk the ARP and device cells side by side. A route miss
//   gives its result once the key leaves the last route cell; otherwise the
//   result is ready once both the ARP and the device tokens have come out.
//   The next command is taken once the result moves into the output register.
//   Reset clears all valid bits; every table is empty afterwards.
//   A stalled receiver holds the result in the output register; a finished
//   next result waits until that register is taken.
`default_nettype none

module next_hop_forwarding_lookup_unit
	import nhfl_pkg::*;
#(
	parameter int ROUTE_ENTRIES  = 16,
	parameter int ARP_ENTRIES    = 16,
	parameter int DEVICE_ENTRIES = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// entry_index[3:0], dest_ip[35:4], gateway_ip[67:36], iface_ip[99:68],
	// station_mac[147:100], if_number[163:148], zero[167:164]
	input  wire logic [167:0] s_axis_tdata,
	// opcode[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// next_hop_mac[47:0], out_ifindex[63:48]
	output logic [63:0]       m_axis_tdata,
	// status[2:0]
	output logic [2:0]        m_axis_tuser
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ROUTE = 4'b0010,
		S_TAIL  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	op_t              opcode;
	logic [3:0]       entry_index;
	logic [KEY_W-1:0] dest_ip;
	logic [KEY_W-1:0] gateway_ip;
	logic [KEY_W-1:0] iface_ip;
	logic [MAC_W-1:0] station_mac;
	logic [IFN_W-1:0] if_number;
	logic             accept;

	wr_t  route_wr, arp_wr, dev_wr;
	tok_t route_tok_in, route_tok_out;
	tok_t arp_tok_in, arp_tok_out;
	tok_t dev_tok_in, dev_tok_out;

	logic             arp_done_q, dev_done_q;
	logic             arp_hit_q, dev_hit_q;
	logic [MAC_W-1:0] mac_q;
	logic [IFN_W-1:0] ifn_q;
	logic             arp_got, dev_got, arp_hit, dev_hit;
	logic [MAC_W-1:0] mac_w;
	logic [IFN_W-1:0] ifn_w;

	res_t res_q, res_d;
	logic res_load;
	logic out_vld_q;
	res_t out_res_q;
	logic out_load;

	assign opcode      = op_t'(s_axis_tuser);
	assign entry_index = s_axis_tdata[3:0];
	assign dest_ip     = s_axis_tdata[35:4];
	assign gateway_ip  = s_axis_tdata[67:36];
	assign iface_ip    = s_axis_tdata[99:68];
	assign station_mac = s_axis_tdata[147:100];
	assign if_number   = s_axis_tdata[163:148];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign route_wr.en   = accept && opcode == OP_WR_ROUTE;
	assign route_wr.idx  = IDX_W'(entry_index);
	assign route_wr.key  = dest_ip;
	assign route_wr.data = {iface_ip, gateway_ip};

	assign arp_wr.en     = accept && opcode == OP_WR_ARP;
	assign arp_wr.idx    = IDX_W'(entry_index);
	assign arp_wr.key    = gateway_ip;
	assign arp_wr.data   = TOK_DATA_W'(station_mac);

	assign dev_wr.en     = accept && opcode == OP_WR_DEVICE;
	assign dev_wr.idx    = IDX_W'(entry_index);
	assign dev_wr.key    = iface_ip;
	assign dev_wr.data   = TOK_DATA_W'(if_number);

	assign route_tok_in.vld  = accept && opcode == OP_LOOKUP;
	assign route_tok_in.hit  = 1'b0;
	assign route_tok_in.key  = dest_ip;
	assign route_tok_in.data = '0;

	// route data: gateway in the low word, interface address in the high word
	assign arp_tok_in.vld  = state_q == S_ROUTE && route_tok_out.vld && route_tok_out.hit;
	assign arp_tok_in.hit  = 1'b0;
	assign arp_tok_in.key  = route_tok_out.data[KEY_W-1:0];
	assign arp_tok_in.data = '0;

	assign dev_tok_in.vld  = arp_tok_in.vld;
	assign dev_tok_in.hit  = 1'b0;
	assign dev_tok_in.key  = route_tok_out.data[2*KEY_W-1:KEY_W];
	assign dev_tok_in.data = '0;

	nhfl_chain #(.ENTRIES(ROUTE_ENTRIES), .DATA_W(2*KEY_W)) u_route (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (route_wr),
		.tok_in  (route_tok_in),
		.tok_out (route_tok_out)
	);

	nhfl_chain #(.ENTRIES(ARP_ENTRIES), .DATA_W(MAC_W)) u_arp (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (arp_wr),
		.tok_in  (arp_tok_in),
		.tok_out (arp_tok_out)
	);

	nhfl_chain #(.ENTRIES(DEVICE_ENTRIES), .DATA_W(IFN_W)) u_dev (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (dev_wr),
		.tok_in  (dev_tok_in),
		.tok_out (dev_tok_out)
	);

	assign arp_got = arp_done_q || arp_tok_out.vld;
	assign dev_got = dev_done_q || dev_tok_out.vld;
	assign arp_hit = arp_tok_out.vld ? arp_tok_out.hit : arp_hit_q;
	assign dev_hit = dev_tok_out.vld ? dev_tok_out.hit : dev_hit_q;
	assign mac_w   = arp_tok_out.vld ? arp_tok_out.data[MAC_W-1:0] : mac_q;
	assign ifn_w   = dev_tok_out.vld ? dev_tok_out.data[IFN_W-1:0] : ifn_q;

	assign out_load = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res_d    = '{status: ST_WRITE_DONE, mac: '0, ifidx: '0};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_LOOKUP) begin
						state_d = S_ROUTE;
					end else begin
						res_load = 1'b1;
						state_d  = S_DONE;
					end
				end
			end
			S_ROUTE: begin
				if (route_tok_out.vld) begin
					if (route_tok_out.hit) begin
						state_d = S_TAIL;
					end else begin
						res_d.status = ST_NO_ROUTE;
						res_load     = 1'b1;
						state_d      = S_DONE;
					end
				end
			end
			S_TAIL: begin
				if (arp_got && dev_got) begin
					res_load = 1'b1;
					state_d  = S_DONE;
					if (!arp_hit) begin
						res_d.status = ST_NO_ARP;
					end else if (!dev_hit) begin
						res_d.status = ST_NO_DEVICE;
					end else begin
						res_d.status = ST_FORWARDED;
						res_d.mac    = mac_w;
						res_d.ifidx  = ifn_w;
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			arp_done_q <= 1'b0;
			dev_done_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_TAIL) begin
				arp_done_q <= arp_got;
				dev_done_q <= dev_got;
			end else begin
				arp_done_q <= 1'b0;
				dev_done_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arp_tok_out.vld) begin
			arp_hit_q <= arp_tok_out.hit;
			mac_q     <= arp_tok_out.data[MAC_W-1:0];
		end
		if (dev_tok_out.vld) begin
			dev_hit_q <= dev_tok_out.hit;
			ifn_q     <= dev_tok_out.data[IFN_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_res_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_res_q.ifidx, out_res_q.mac};
	assign m_axis_tuser  = out_res_q.status;

`ifndef SYNTH
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_ROUTE || state_q == S_DONE)
		else $error("accepted transaction did not start processing");

	a_route_tok_state: assert property (@(posedge clk) disable iff (!arst_n)
		route_tok_out.vld |-> state_q == S_ROUTE)
		else $error("route search token outside route phase");

	a_tail_tok_state: assert property (@(posedge clk) disable iff (!arst_n)
		(arp_tok_out.vld || dev_tok_out.vld) |-> state_q == S_TAIL)
		else $error("ARP or device token outside tail phase");

	a_tail_sync: assert property (@(posedge clk) disable iff (!arst_n)
		arp_tok_in.vld |-> dev_tok_in.vld && !arp_done_q && !dev_done_q)
		else $error("tail chains not launched together");
`endif

endmodule

`default_nettype wire

FILE: hdl/nhfl_cell.sv
// One table entry: stores key and data, matches the passing search token.
`default_nettype none

module nhfl_cell
	import nhfl_pkg::*;
#(
	parameter int IDX    = 0,
	parameter int DATA_W = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire wr_t  wr,
	input  wire tok_t tok_in,
	output tok_t      tok_out
);

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              valid_q;
	tok_t              tok_q;
	logic              match;

	assign match   = valid_q && !tok_in.hit && (key_q == tok_in.key);
	assign tok_out = tok_q;

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == IDX_W'(IDX)) begin
			key_q  <= wr.key;
			data_q <= wr.data[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (wr.en && wr.idx == IDX_W'(IDX)) begin
				valid_q <= 1'b1;
			end
			tok_q.vld  <= tok_in.vld;
			tok_q.hit  <= tok_in.hit | match;
			tok_q.key  <= tok_in.key;
			tok_q.data <= match ? TOK_DATA_W'(data_q) : tok_in.data;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/nhfl_chain.sv
// Row of entry cells forming one exact-match table; lowest index wins.
`default_nettype none

module nhfl_chain
	import nhfl_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int DATA_W  = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire wr_t  wr,
	input  wire tok_t tok_in,
	output tok_t      tok_out
);

	tok_t tok_w [ENTRIES+1];

	assign tok_w[0] = tok_in;
	assign tok_out  = tok_w[ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		nhfl_cell #(
			.IDX    (i),
			.DATA_W (DATA_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.tok_in  (tok_w[i]),
			.tok_out (tok_w[i+1])
		);
	end

endmodule

`default_nettype wire

FILE: verif/next_hop_forwarding_lookup_checker.sv
// Checker for the next-hop forwarding lookup block: predicts every result and compares it.
`timescale 1ns / 100ps

module next_hop_forwarding_lookup_checker
	import nhfl_pkg::*;
#(
	parameter int ROUTE_N = 16,
	parameter int ARP_N   = 16,
	parameter int DEV_N   = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [167:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic [2:0]   m_tuser,
	output int           fail_count,
	output int           pending
);

	logic [31:0] rt_dst [ROUTE_N];
	logic [31:0] rt_gw  [ROUTE_N];
	logic [31:0] rt_if  [ROUTE_N];
	logic        rt_vld [ROUTE_N];
	logic [31:0] arp_key [ARP_N];
	logic [47:0] arp_hw  [ARP_N];
	logic        arp_vld [ARP_N];
	logic [31:0] dev_key [DEV_N];
	logic [15:0] dev_num [DEV_N];
	logic        dev_vld [DEV_N];

	res_t predicted_hops[$];
	int   fails = 0;
	int   outstanding = 0;

	assign fail_count = fails;
	assign pending    = outstanding;

	function automatic res_t resolve_next_hop(input op_t op, input logic [3:0] idx,
			input logic [31:0] dst, input logic [31:0] gw, input logic [31:0] ifa,
			input logic [47:0] mac, input logic [15:0] ifn);
		res_t res;
		int   r;
		int   a;
		int   d;
		res.status = ST_WRITE_DONE;
		res.mac    = '0;
		res.ifidx  = '0;
		case (op)
			OP_WR_ROUTE: begin
				if (idx < ROUTE_N) begin
					rt_dst[idx] = dst;
					rt_gw[idx]  = gw;
					rt_if[idx]  = ifa;
					rt_vld[idx] = 1'b1;
				end
			end
			OP_WR_ARP: begin
				if (idx < ARP_N) begin
					arp_key[idx] = gw;
					arp_hw[idx]  = mac;
					arp_vld[idx] = 1'b1;
				end
			end
			OP_WR_DEVICE: begin
				if (idx < DEV_N) begin
					dev_key[idx] = ifa;
					dev_num[idx] = ifn;
					dev_vld[idx] = 1'b1;
				end
			end
			default: begin
				r = -1;
				a = -1;
				d = -1;
				for (int k = ROUTE_N - 1; k >= 0; k--)
					if (rt_vld[k] && rt_dst[k] == dst) r = k;
				if (r < 0) begin
					res.status = ST_NO_ROUTE;
				end else begin
					for (int k = ARP_N - 1; k >= 0; k--)
						if (arp_vld[k] && arp_key[k] == rt_gw[r]) a = k;
					for (int k = DEV_N - 1; k >= 0; k--)
						if (dev_vld[k] && dev_key[k] == rt_if[r]) d = k;
					if (a < 0) begin
						res.status = ST_NO_ARP;
					end else if (d < 0) begin
						res.status = ST_NO_DEVICE;
					end else begin
						res.status = ST_FORWARDED;
						res.mac    = arp_hw[a];
						res.ifidx  = dev_num[d];
					end
				end
			end
		endcase
		return res;
	endfunction

	task automatic check_result();
		res_t want;
		if (predicted_hops.size() == 0) begin
			$error("result transaction with nothing outstanding: status %0d", m_tuser);
			fails++;
		end else begin
			want = predicted_hops.pop_front();
			outstanding--;
			if (want.status !== m_tuser) begin
				$error("status: expected %0d, got %0d", want.status, m_tuser);
				fails++;
			end
			if (want.mac !== m_tdata[47:0]) begin
				$error("next_hop_mac: expected %h, got %h", want.mac, m_tdata[47:0]);
				fails++;
			end
			if (want.ifidx !== m_tdata[63:48]) begin
				$error("out_ifindex: expected %h, got %h", want.ifidx, m_tdata[63:48]);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROUTE_N; k++) rt_vld[k] = 1'b0;
			for (int k = 0; k < ARP_N; k++) arp_vld[k] = 1'b0;
			for (int k = 0; k < DEV_N; k++) dev_vld[k] = 1'b0;
			predicted_hops.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready) begin
				predicted_hops.push_back(resolve_next_hop(op_t'(s_tuser), s_tdata[3:0],
					s_tdata[35:4], s_tdata[67:36], s_tdata[99:68], s_tdata[147:100],
					s_tdata[163:148]));
				outstanding++;
			end
		end
	end

endmodule

FILE: verif/next_hop_forwarding_lookup_unit_tb.sv
// Testbench top for the next-hop forwarding lookup block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module next_hop_forwarding_lookup_unit_tb;
	import nhfl_pkg::*;

	localparam int ROUTE_N         = 16;
	localparam int ARP_N           = 16;
	localparam int DEV_N           = 4;
	localparam int ITEMS_PER_PHASE = 400;
	localparam int POOL_N          = 6;
	localparam int POOL_DST        = 0;
	localparam int POOL_GW         = 1;
	localparam int POOL_IF         = 2;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 40;

	localparam int TX_IDLE [4]  = '{0, 75, 0, 33};
	localparam int RX_STALL [4] = '{0, 0, 75, 33};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// entry_index, dest_ip, gateway_ip, iface_ip, station_mac, if_number, zero pad
	logic [167:0] s_axis_tdata = '0;
	// opcode
	logic [1:0]   s_axis_tuser = OP_LOOKUP;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// next_hop_mac, out_ifindex
	logic [63:0]  m_axis_tdata;
	// status
	logic [2:0]   m_axis_tuser;

	int          fail_count;
	int          pending;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	logic        hold_toggle = 1'b0;
	logic        hold_seen;
	int          hold_left;
	int          quiet_cycles = 0;
	logic [31:0] addr_pool [3][POOL_N];

	always #5 clk = ~clk;

	next_hop_forwarding_lookup_unit #(
		.ROUTE_ENTRIES (ROUTE_N),
		.ARP_ENTRIES   (ARP_N),
		.DEVICE_ENTRIES(DEV_N)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	next_hop_forwarding_lookup_checker #(
		.ROUTE_N(ROUTE_N),
		.ARP_N  (ARP_N),
		.DEV_N  (DEV_N)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// result sink: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen     <= 1'b0;
			hold_left     <= 0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen     <= hold_toggle;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic logic [31:0] pick_key(input int which);
		if ($urandom_range(99) < 90)
			return addr_pool[which][$urandom_range(POOL_N - 1)];
		return $urandom;
	endfunction

	// fresh keys each phase so stale entries stop matching and misses recur
	task automatic refresh_pools();
		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < POOL_N; k++)
				addr_pool[p][k] = $urandom;
			addr_pool[p][0] = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
		end
	endtask

	task automatic send_cmd(input op_t op, input logic [3:0] idx, input logic [31:0] dst,
			input logic [31:0] gw, input logic [31:0] ifa, input logic [47:0] mac,
			input logic [15:0] ifn);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, ifn, mac, ifa, gw, dst, idx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random_cmd();
		int          pick;
		logic [3:0]  idx;
		pick = $urandom_range(99);
		idx  = 4'($urandom_range(15));
		if (pick < 40) begin
			send_cmd(OP_LOOKUP, idx, pick_key(POOL_DST), $urandom, $urandom, rand48(),
				16'($urandom_range(16'hFFFF)));
		end else if (pick < 65) begin
			send_cmd(OP_WR_ROUTE, idx, pick_key(POOL_DST), pick_key(POOL_GW),
				pick_key(POOL_IF), rand48(), 16'($urandom_range(16'hFFFF)));
		end else if (pick < 85) begin
			send_cmd(OP_WR_ARP, idx, $urandom, pick_key(POOL_GW), $urandom, rand48(),
				16'($urandom_range(16'hFFFF)));
		end else begin
			if ($urandom_range(99) < 75)
				idx = 4'($urandom_range(DEV_N - 1));
			else
				idx = 4'($urandom_range(15, DEV_N));
			send_cmd(OP_WR_DEVICE, idx, $urandom, $urandom, pick_key(POOL_IF), rand48(),
				16'($urandom_range(16'hFFFF)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables, then build one path stage by stage
		send_cmd(OP_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd15, '1, '1, '1, '1, '1);
		send_cmd(OP_WR_ROUTE, 4'd0, '1, 32'h0, '1, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_WR_ARP, 4'd15, 32'h0, 32'h0, 32'h0, '1, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_WR_DEVICE, 4'd3, 32'h0, 32'h0, '1, 48'h0, '1);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		// device slots past the table end are dropped
		send_cmd(OP_WR_DEVICE, 4'd4, 32'h0, 32'h0, '1, 48'h0, 16'h0);
		send_cmd(OP_WR_DEVICE, 4'd15, 32'h0, 32'h0, '1, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		// duplicate keys: lowest slot wins
		send_cmd(OP_WR_ROUTE, 4'd15, '1, 32'h1, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_WR_ARP, 4'd0, 32'h0, 32'h0, 32'h0, 48'h0123_4567_89AB, 16'h0);
		send_cmd(OP_WR_DEVICE, 4'd0, 32'h0, 32'h0, '1, 48'h0, 16'h5A5A);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		// rewrite of a live slot
		send_cmd(OP_WR_ROUTE, 4'd0, '1, 32'h1, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_WR_ARP, 4'd1, 32'h0, 32'h1, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_WR_DEVICE, 4'd1, 32'h0, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, '1, 32'h0, 32'h0, 48'h0, 16'h0);
		send_cmd(OP_WR_ROUTE, 4'd7, 32'h0, 32'h0, '1, 48'h0, 16'h0);
		send_cmd(OP_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 48'h0, 16'h0);

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = TX_IDLE[ph];
			rx_stall_pct <= RX_STALL[ph];
			refresh_pools();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					hold_toggle <= ~hold_toggle;
				send_random_cmd();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
